// ===== rtl/assert_macros.svh =====
// Assertion macros used by the counter top level, clocked on aclk and muted during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/sscnt_pkg.sv =====
// Shared types and constants of the substring occurrence counter
`timescale 1ns / 1ps
package sscnt_pkg;

    localparam int BYTE_W        = 8;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int PAT_LEN_W     = 5;
    localparam int PAT_BYTES     = 16;
    localparam int PAT_IDX_W     = 4;
    localparam int IN_TDATA_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd2;

    typedef struct packed {
        logic shift;
        logic clear;
    } sscnt_ctrl_t;

endpackage

// ===== rtl/substring_occurrence_counter_unit.sv =====
// Top level: pattern registers, cell chain, match counter and output register
//
//  port group   dir  word contents
//  s_axis       in   tdata[7:0] text_byte, tlast text_last
//  m_axis       out  tdata[0] match_here, tdata[COUNT_BITS:1] match_total, tlast end_of_text
//  cfg_wr       in   index 0 pattern low, 1 pattern high, 2 pattern length
//
// One word per cycle in and out unless m_tready stalls; a result appears in the cycle after its word is taken.
// The cell chain compares the whole window in the accepting cycle, then the counter adds.
// s_tready stays high while the output register is empty or being drained.
// Reset clears the window, the count and the registers (pattern length 1).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module substring_occurrence_counter_unit #(
    parameter int MAX_PATTERN = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [sscnt_pkg::IN_TDATA_W-1:0]      s_tdata,   // [7:0] text_byte
    input  logic                                  s_tlast,   // text_last
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((COUNT_BITS+8)/8)*8-1:0]       m_tdata,   // [0] match_here, then match_total
    output logic                                  m_tlast,   // end_of_text
    input  logic                                  cfg_wr_en,
    input  logic [sscnt_pkg::CFG_IDX_W-1:0]       cfg_wr_idx,
    input  logic [sscnt_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import sscnt_pkg::*;

    localparam logic [PAT_LEN_W-1:0] MAX_LEN = PAT_LEN_W'(MAX_PATTERN);

    logic [CFG_DATA_W-1:0] pat_lo_reg;
    logic [CFG_DATA_W-1:0] pat_hi_reg;
    logic [PAT_LEN_W-1:0]  pat_len_reg;
    logic [PAT_LEN_W-1:0]  len_used;
    logic [BYTE_W-1:0]     pat_arr [PAT_BYTES];

    logic                  in_acc;
    sscnt_ctrl_t           ctrl;
    logic [BYTE_W-1:0]     tap_byte [MAX_PATTERN+1];
    logic [MAX_PATTERN:0]  tap_valid;
    logic [MAX_PATTERN-1:0] ok_vec;
    logic                  hit;

    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_next;

    logic                  m_tvalid_reg;
    logic                  out_match_reg;
    logic [COUNT_BITS-1:0] out_total_reg;
    logic                  out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= PAT_LEN_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_wr_idx)
                CFG_PAT_LO:  pat_lo_reg  <= cfg_wr_data;
                CFG_PAT_HI:  pat_hi_reg  <= cfg_wr_data;
                CFG_PAT_LEN: pat_len_reg <= cfg_wr_data[PAT_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (pat_len_reg == '0) begin
            len_used = PAT_LEN_W'(1);
        end else if (pat_len_reg > MAX_LEN) begin
            len_used = MAX_LEN;
        end else begin
            len_used = pat_len_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < PAT_BYTES / 2; i++) begin
            pat_arr[i]                 = pat_lo_reg[i*BYTE_W +: BYTE_W];
            pat_arr[i + PAT_BYTES / 2] = pat_hi_reg[i*BYTE_W +: BYTE_W];
        end
    end

    assign s_tready   = !m_tvalid_reg || m_tready;
    assign in_acc     = s_tvalid && s_tready;
    assign ctrl.shift = in_acc;
    assign ctrl.clear = in_acc && s_tlast;

    assign tap_byte[0]  = s_tdata[BYTE_W-1:0];
    assign tap_valid[0] = 1'b1;

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        localparam logic [PAT_LEN_W-1:0] POS = PAT_LEN_W'(j);
        logic [PAT_LEN_W-1:0] pat_idx;
        logic                 active;

        assign active  = POS < len_used;
        assign pat_idx = len_used - PAT_LEN_W'(1) - POS;

        sscnt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .byte_in   (tap_byte[j]),
            .valid_in  (tap_valid[j]),
            .pat_byte  (pat_arr[pat_idx[PAT_IDX_W-1:0]]),
            .active    (active),
            .byte_out  (tap_byte[j+1]),
            .valid_out (tap_valid[j+1]),
            .ok        (ok_vec[j])
        );
    end

    assign hit = &ok_vec;

    always_comb begin
        total_next = total_reg;
        if (hit && (total_reg != '1)) begin
            total_next = total_reg + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (in_acc) begin
                total_reg <= s_tlast ? '0 : total_next;
            end
            if (in_acc) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            out_match_reg <= hit;
            out_total_reg <= total_next;
            out_last_reg  <= s_tlast;
        end
    end

    always_comb begin
        m_tdata                = '0;
        m_tdata[0]             = out_match_reg;
        m_tdata[COUNT_BITS:1]  = out_total_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;

    `ASSERT_NEXT(a_clear_after_last, in_acc && s_tlast, (total_reg == '0) && (tap_valid[MAX_PATTERN:1] == '0))
    `ASSERT_SAME(a_match_counts, m_tvalid && m_tdata[0], m_tdata[COUNT_BITS:1] != '0)
    `ASSERT_SAME(a_taps_in_order, 1'b1, (tap_valid[MAX_PATTERN:1] & (tap_valid[MAX_PATTERN:1] + 1'b1)) == '0)
    `ASSERT_NEXT(a_total_monotonic, in_acc && !s_tlast, total_reg >= $past(total_reg))

endmodule

// ===== rtl/sscnt_cell.sv =====
// One window cell: holds a text byte and its valid flag, compares its incoming byte against its pattern byte
`timescale 1ns / 1ps
module sscnt_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sscnt_pkg::sscnt_ctrl_t      ctrl,
    input  logic [sscnt_pkg::BYTE_W-1:0] byte_in,
    input  logic                        valid_in,
    input  logic [sscnt_pkg::BYTE_W-1:0] pat_byte,
    input  logic                        active,
    output logic [sscnt_pkg::BYTE_W-1:0] byte_out,
    output logic                        valid_out,
    output logic                        ok
);
    import sscnt_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic              valid_reg;
    logic              valid_next;

    always_comb begin
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.shift) begin
            valid_next = valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            byte_reg <= byte_in;
        end
    end

    assign ok        = !active || (valid_in && (byte_in == pat_byte));
    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

// ===== verif/substring_occurrence_counter_unit_tb.sv =====
// Testbench: directed and random byte streams checked word by word against a match counter model
`timescale 1ns / 1ps
module substring_occurrence_counter_unit_tb;
    import sscnt_pkg::*;

    localparam int COUNT_W = 16;
    localparam int OUT_W   = ((COUNT_W + 8) / 8) * 8;
    localparam int WIN_D   = PAT_BYTES - 1;

    typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic [BYTE_W-1:0]       text_byte;
        logic                    text_last;
        logic                    typed;
        logic                    t_hit;
        logic [COUNT_W-1:0]      t_total;
    } stim_row_t;

    typedef struct {
        logic               hit;
        logic [COUNT_W-1:0] total;
        logic               last;
    } count_word_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_W-1:0]        m_tdata;
    logic                    m_tlast;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_wr_idx;
    logic [CFG_DATA_W-1:0]   cfg_wr_data;

    // model state
    logic [CFG_DATA_W-1:0]   pat_lo;
    logic [CFG_DATA_W-1:0]   pat_hi;
    logic [PAT_LEN_W-1:0]    pat_len;
    logic [BYTE_W-1:0]       win_bytes [WIN_D];
    int unsigned             seen_cnt;
    logic [COUNT_W-1:0]      run_total;

    count_word_t             pending_counts [$];
    stim_row_t               stim_rows [$];
    int unsigned             fail_count;
    int unsigned             words_sent;
    logic                    idle_on;

    substring_occurrence_counter_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(50_000_000);
        $display("Regression FAIL");
        $finish;
    end

    function automatic int used_len();
        if (pat_len == '0) return 1;
        if (pat_len > PAT_BYTES) return PAT_BYTES;
        return int'(pat_len);
    endfunction

    function automatic logic [BYTE_W-1:0] pat_byte(input int k);
        logic [2*CFG_DATA_W-1:0] pat_all;
        pat_all = {pat_hi, pat_lo};
        return pat_all[8*k +: 8];
    endfunction

    function automatic void clear_text();
        for (int k = 0; k < WIN_D; k++) win_bytes[k] = '0;
        seen_cnt  = 0;
        run_total = '0;
    endfunction

    function automatic void count_step(input logic [BYTE_W-1:0] b, input logic l,
                                       output logic hit, output logic [COUNT_W-1:0] tot);
        int n;
        n   = used_len();
        hit = 1'b0;
        if (int'(seen_cnt) + 1 >= n) begin
            hit = (pat_byte(n - 1) == b);
            for (int k = 1; k < n; k++)
                if (pat_byte(n - 1 - k) != win_bytes[k - 1]) hit = 1'b0;
        end
        if (hit && run_total != '1) run_total = run_total + 1'b1;
        tot = run_total;
        if (l) begin
            clear_text();
        end else begin
            for (int k = WIN_D - 1; k > 0; k--) win_bytes[k] = win_bytes[k - 1];
            win_bytes[0] = b;
            if (seen_cnt < PAT_BYTES) seen_cnt++;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < 40)
            $display("MISMATCH %s: got %0h want %0h (word %0d)", what, got, want, words_sent);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        count_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_counts.size() == 0) begin
                report_mismatch("unexpected word", 64'(m_tdata), 64'(0));
            end else begin
                want = pending_counts.pop_front();
                if (m_tdata[0] !== want.hit)
                    report_mismatch("match_here", 64'(m_tdata[0]), 64'(want.hit));
                if (m_tdata[COUNT_W:1] !== want.total)
                    report_mismatch("match_total", 64'(m_tdata[COUNT_W:1]), 64'(want.total));
                if (m_tlast !== want.last)
                    report_mismatch("end_of_text", 64'(m_tlast), 64'(want.last));
            end
        end
    end

    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        hold_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            CFG_PAT_LO:  pat_lo  = data;
            CFG_PAT_HI:  pat_hi  = data;
            CFG_PAT_LEN: pat_len = data[PAT_LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_word(input logic [BYTE_W-1:0] b, input logic l, input logic typed,
                             input logic t_hit, input logic [COUNT_W-1:0] t_total);
        count_word_t w;
        cfg_wr_en <= 1'b0;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        count_step(b, l, w.hit, w.total);
        w.last = l;
        if (typed) begin
            w.hit   = t_hit;
            w.total = t_total;
        end
        pending_counts.push_back(w);
        words_sent++;
    endtask

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r = '{ROW_CFG, idx, data, '0, 1'b0, 1'b0, 1'b0, '0};
        stim_rows.push_back(r);
    endfunction

    function automatic void add_word(input logic [BYTE_W-1:0] b, input logic l, input logic typed,
                                     input logic t_hit, input logic [COUNT_W-1:0] t_total);
        stim_row_t r;
        r = '{ROW_WORD, '0, '0, b, l, typed, t_hit, t_total};
        stim_rows.push_back(r);
    endfunction

    initial begin
        logic [BYTE_W-1:0]      long_pat [PAT_BYTES];
        logic [CFG_DATA_W-1:0]  rnd;
        logic [BYTE_W-1:0]      b;
        logic [BYTE_W-1:0]      alpha [2];
        int                     n;
        int                     ptr;
        int                     text_n;
        int                     sel;
        int unsigned            setting_start;
        int unsigned            waited;

        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_idx  <= '0;
        cfg_wr_data <= '0;
        idle_on     = 1'b1;
        fail_count  = 0;
        words_sent  = 0;
        pat_lo      = '0;
        pat_hi      = '0;
        pat_len     = 5'd1;
        clear_text();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset the pattern is a single zero byte
        add_word(8'h00, 1'b0, 1'b1, 1'b1, 16'd1);
        add_word(8'hFF, 1'b1, 1'b1, 1'b0, 16'd1);
        add_word(8'h00, 1'b1, 1'b1, 1'b1, 16'd1);
        // pattern ABA, short text, then overlapping hits
        add_cfg(CFG_PAT_LO, 64'h0123_4567_8941_4241);
        add_cfg(CFG_PAT_LEN, 64'd3);
        add_word(8'h41, 1'b0, 1'b1, 1'b0, 16'd0);
        add_word(8'h42, 1'b1, 1'b1, 1'b0, 16'd0);
        add_word(8'h41, 1'b0, 1'b0, 1'b0, '0);
        add_word(8'h42, 1'b0, 1'b0, 1'b0, '0);
        add_word(8'h41, 1'b0, 1'b0, 1'b0, '0);
        add_word(8'h42, 1'b0, 1'b0, 1'b0, '0);
        add_word(8'h41, 1'b1, 1'b0, 1'b0, '0);
        // length zero acts as one
        add_cfg(CFG_PAT_LEN, 64'd0);
        add_word(8'h41, 1'b1, 1'b1, 1'b1, 16'd1);
        // length above the maximum acts as sixteen
        add_cfg(CFG_PAT_HI, 64'hFFEE_DDCC_BBAA_9988);
        add_cfg(CFG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
        long_pat = '{8'h41, 8'h42, 8'h41, 8'h89, 8'h67, 8'h45, 8'h23, 8'h01,
                     8'h88, 8'h99, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hEE, 8'hFF};
        for (int k = 0; k < PAT_BYTES; k++)
            add_word(long_pat[k], k == PAT_BYTES - 1, 1'b0, 1'b0, '0);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG)
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            else
                send_word(stim_rows[i].text_byte, stim_rows[i].text_last, stim_rows[i].typed,
                          stim_rows[i].t_hit, stim_rows[i].t_total);
        end

        setting_start = words_sent;
        while (words_sent - setting_start < 1800) begin
            sel = $urandom_range(0, 5);
            rnd = {$urandom, $urandom};
            case (sel)
                0: rnd[PAT_LEN_W-1:0] = 5'd1;
                1: rnd[PAT_LEN_W-1:0] = 5'd16;
                2: rnd[PAT_LEN_W-1:0] = 5'($urandom_range(0, 31));
                default: rnd[PAT_LEN_W-1:0] = 5'($urandom_range(2, 15));
            endcase
            write_reg(CFG_PAT_LEN, rnd);
            alpha[0] = 8'($urandom);
            alpha[1] = 8'($urandom);
            if ($urandom_range(0, 1) == 0) begin
                // two-letter pattern for dense overlapping hits
                for (int k = 0; k < 8; k++) rnd[8*k +: 8] = alpha[$urandom_range(0, 1)];
                write_reg(CFG_PAT_LO, rnd);
                for (int k = 0; k < 8; k++) rnd[8*k +: 8] = alpha[$urandom_range(0, 1)];
                write_reg(CFG_PAT_HI, rnd);
            end else begin
                write_reg(CFG_PAT_LO, {$urandom, $urandom});
                write_reg(CFG_PAT_HI, {$urandom, $urandom});
            end
            n = used_len();
            for (int t = 0; t < 6; t++) begin
                if (words_sent - setting_start > 1600) idle_on = 1'b0;
                if ($urandom_range(0, 3) == 0) hold_until_drained();
                text_n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n)
                                                     : $urandom_range(1, 50);
                ptr = 0;
                for (int i = 0; i < text_n; i++) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 6) begin
                        b   = pat_byte(ptr);
                        ptr = (ptr + 1) % n;
                        if ($urandom_range(0, 9) == 0) ptr = 0;
                    end else if (sel < 8) begin
                        b = pat_byte($urandom_range(0, n - 1));
                    end else if (sel == 8) begin
                        b = alpha[$urandom_range(0, 1)];
                    end else begin
                        b = 8'($urandom);
                    end
                    send_word(b, i == text_n - 1, 1'b0, 1'b0, '0);
                end
            end
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_counts.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
        if (pending_counts.size() != 0)
            report_mismatch("words never returned", 64'(pending_counts.size()), 64'(0));
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
